// ===== design/sabc_pkg.sv =====
package sabc_pkg;

  localparam int BLK_W    = 32;
  localparam int HANDLE_W = 32;

  localparam logic MODE_LOOKUP = 1'b0;
  localparam logic MODE_INSERT = 1'b1;

  typedef struct packed {
    logic                mode;
    logic [BLK_W-1:0]    block_number;
    logic [HANDLE_W-1:0] payload_handle;
  } in_item_t;

  typedef struct packed {
    logic                hit;
    logic [HANDLE_W-1:0] hit_handle;
  } out_item_t;

  typedef struct packed {
    logic                valid;
    logic [BLK_W-1:0]    tag;
    logic [HANDLE_W-1:0] handle;
  } line_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mod_status_t;

endpackage

// ===== design/set_associative_block_cache_unit.sv =====
// Tag store of a set-associative block cache with round-robin replacement.
// A lookup transaction returns one result with the hit flag and the handle of
// the lowest matching way; an insert transaction writes the way under the
// set's replacement pointer and returns nothing. After reset the block runs a
// clearing pass over all SETS*WAYS lines, one line per cycle, before it takes the
// first transaction. The set index is formed by a remainder unit that
// multiplies the block number by a fixed reciprocal of SETS, one half of the
// block number per cycle on a shared 16 by 33 bit multiplier, and reuses that
// multiplier in a third step to finish the remainder. For a lookup the ways
// are then read one at a time through a single port of the line memory and
// one tag comparator, each way passing through a read state and a compare
// state. An insert instead reads the set's pointer, then writes the line and
// advances the pointer. A finished lookup result waits while the previous one
// is still stalled in the output register.
module set_associative_block_cache_unit #(
  parameter int SETS = 64,
  parameter int WAYS = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sabc_pkg::in_item_t  in_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output sabc_pkg::out_item_t out_data_o,
  output logic                out_valid_o,
  input  logic                out_stall_i
);

  import sabc_pkg::*;

  localparam int LINES  = SETS * WAYS;
  localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int LINE_W = (LINES > 1) ? $clog2(LINES) : 1;

  typedef enum logic [7:0] {
    ST_CLEAR = 8'b0000_0001,
    ST_IDLE  = 8'b0000_0010,
    ST_MOD   = 8'b0000_0100,
    ST_PTR   = 8'b0000_1000,
    ST_INS   = 8'b0001_0000,
    ST_RD    = 8'b0010_0000,
    ST_CMP   = 8'b0100_0000,
    ST_DONE  = 8'b1000_0000
  } state_e;

  state_e            state_q, state_d;
  logic [LINE_W-1:0] clr_q, clr_d;
  logic [WAY_W-1:0]  way_q, way_d;
  logic [SET_W-1:0]  set_q, set_d;
  in_item_t          item_q, item_d;
  out_item_t         res_q, res_d;
  out_item_t         out_q, out_d;
  logic              out_valid_q, out_valid_d;

  logic              in_accept;
  mod_status_t       mod_st;
  logic [SET_W-1:0]  mod_rem;

  logic [LINE_W-1:0] base;
  logic              line_we;
  logic [LINE_W-1:0] line_waddr, line_raddr;
  line_t             line_wdata, line_rdata;
  logic              ptr_we;
  logic [SET_W-1:0]  ptr_waddr;
  logic [WAY_W-1:0]  ptr_wdata, ptr_rdata;

  assign in_accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign base = LINE_W'(32'(set_q) * WAYS);

  sabc_mod_unit #(
    .DIVISOR (SETS)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_accept),
    .dividend_i (in_data_i.block_number),
    .status_o   (mod_st),
    .rem_o      (mod_rem)
  );

  sabc_ram #(
    .WIDTH ($bits(line_t)),
    .DEPTH (LINES)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (line_we),
    .waddr_i (line_waddr),
    .wdata_i (line_wdata),
    .raddr_i (line_raddr),
    .rdata_o (line_rdata)
  );

  sabc_ram #(
    .WIDTH (WAY_W),
    .DEPTH (SETS)
  ) u_ptr_ram (
    .clk_i   (clk_i),
    .we_i    (ptr_we),
    .waddr_i (ptr_waddr),
    .wdata_i (ptr_wdata),
    .raddr_i (set_q),
    .rdata_o (ptr_rdata)
  );

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    way_d       = way_q;
    set_d       = set_q;
    item_d      = item_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    line_we     = 1'b0;
    line_waddr  = base + LINE_W'(ptr_rdata);
    line_wdata  = '{valid: 1'b1, tag: item_q.block_number, handle: item_q.payload_handle};
    line_raddr  = base + LINE_W'(way_q);
    ptr_we      = 1'b0;
    ptr_waddr   = set_q;
    ptr_wdata   = (ptr_rdata == WAY_W'(WAYS - 1)) ? '0 : ptr_rdata + 1'b1;

    unique case (state_q)
      ST_CLEAR: begin
        line_we    = 1'b1;
        line_waddr = clr_q;
        line_wdata = '0;
        ptr_we     = (32'(clr_q) < 32'(SETS));
        ptr_waddr  = clr_q[SET_W-1:0];
        ptr_wdata  = '0;
        clr_d      = clr_q + 1'b1;
        if (clr_q == LINE_W'(LINES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          item_d  = in_data_i;
          state_d = ST_MOD;
        end
      end
      ST_MOD: begin
        if (mod_st.done) begin
          set_d   = mod_rem;
          way_d   = '0;
          state_d = (item_q.mode == MODE_INSERT) ? ST_PTR : ST_RD;
        end
      end
      ST_PTR: begin
        state_d = ST_INS;
      end
      ST_INS: begin
        line_we = 1'b1;
        ptr_we  = 1'b1;
        state_d = ST_IDLE;
      end
      ST_RD: begin
        state_d = ST_CMP;
      end
      ST_CMP: begin
        if (line_rdata.valid && (line_rdata.tag == item_q.block_number)) begin
          res_d   = '{hit: 1'b1, hit_handle: line_rdata.handle};
          state_d = ST_DONE;
        end else if (way_q == WAY_W'(WAYS - 1)) begin
          res_d   = '0;
          state_d = ST_DONE;
        end else begin
          way_d   = way_q + 1'b1;
          state_d = ST_RD;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    way_q  <= way_d;
    set_q  <= set_d;
    item_q <= item_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_accept_starts_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == ST_MOD) && mod_st.busy)
    else $error("Accepted transaction did not start the set index unit.");

  a_mod_done_in_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_st.done |-> (state_q == ST_MOD))
    else $error("Set index completed outside the index phase.");

  a_miss_zero_handle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.hit) |-> (out_q.hit_handle == '0))
    else $error("Miss result carries a nonzero handle.");

endmodule

// ===== design/sabc_ram.sv =====
module sabc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/sabc_mod_unit.sv =====
module sabc_mod_unit #(
  parameter int DIVISOR = 64,
  parameter int REM_OUT_W = (DIVISOR > 1) ? $clog2(DIVISOR) : 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [sabc_pkg::BLK_W-1:0]  dividend_i,
  output sabc_pkg::mod_status_t       status_o,
  output logic [REM_OUT_W-1:0]        rem_o
);

  import sabc_pkg::*;

  localparam int SHIFT   = (DIVISOR > 1) ? $clog2(DIVISOR) : 0;
  localparam int RECIP_W = BLK_W + 1;
  localparam int HALF_W  = BLK_W / 2;
  localparam int PROD_W  = HALF_W + RECIP_W;
  localparam int SUM_W   = BLK_W + RECIP_W;
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << (BLK_W + SHIFT)) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

  typedef enum logic [2:0] {
    STEP_LO  = 3'b001,
    STEP_HI  = 3'b010,
    STEP_REM = 3'b100
  } step_e;

  step_e                step_q, step_d;
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [BLK_W-1:0]     num_q, num_d;
  logic [PROD_W-1:0]    acc_q, acc_d;
  logic [REM_OUT_W-1:0] quo_q, quo_d;
  logic [REM_OUT_W-1:0] rem_q, rem_d;
  logic [HALF_W-1:0]    mul_a;
  logic [RECIP_W-1:0]   mul_b;
  logic [PROD_W-1:0]    prod;
  logic [SUM_W-1:0]     sum;

  assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign sum  = {prod, {HALF_W{1'b0}}} + SUM_W'(acc_q);

  always_comb begin
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    num_d  = num_q;
    acc_d  = acc_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    mul_a  = num_q[HALF_W-1:0];
    mul_b  = RECIP;
    if (start_i) begin
      num_d  = dividend_i;
      step_d = STEP_LO;
      busy_d = 1'b1;
    end else if (busy_q) begin
      unique case (step_q)
        STEP_LO: begin
          acc_d  = prod;
          step_d = STEP_HI;
        end
        STEP_HI: begin
          mul_a  = num_q[BLK_W-1:HALF_W];
          quo_d  = sum[BLK_W+SHIFT +: REM_OUT_W];
          step_d = STEP_REM;
        end
        STEP_REM: begin
          mul_a  = HALF_W'(quo_q);
          mul_b  = RECIP_W'(DIVISOR);
          rem_d  = num_q[REM_OUT_W-1:0] - prod[REM_OUT_W-1:0];
          busy_d = 1'b0;
          done_d = 1'b1;
        end
        default: begin
          busy_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= STEP_LO;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    acc_q <= acc_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign rem_o         = rem_q;

endmodule
